FILE: rtl/core/bpfc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpfc_pkg
// shared types, codes and helpers of the bitmap pixel fetch and colour decode
// ----------------------------------------------------------------------------
package bpfc_pkg;

  // operation codes of an input beat
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS = 7;
  localparam logic [CFG_IDX_BITS-1:0] REG_BASE_PAGE  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FINE_MODE  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LARGE_SIZE = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_COLOR_ON   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_BRIGHT     = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_MASK = 3'd5;

  // pixel selection carried from address generation to colour decode
  typedef struct packed {
    logic       on_screen;
    logic       fine;
    logic [2:0] bit_sel;   // bit of the byte in fine mode, nibble select in bit 0 otherwise
  } pix_sel_t;

  // one rgbi channel level
  function automatic logic [7:0] chan_level(input logic on, input logic inten);
    logic [7:0] lvl;
    if (on) begin
      lvl = inten ? 8'd255 : 8'd170;
    end else begin
      lvl = inten ? 8'd85 : 8'd0;
    end
    return lvl;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/bpfc_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpfc_mem
// byte-wide system memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module bpfc_mem #(
  parameter int unsigned ADDR_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] waddr,
  input  wire logic [7:0]           wdata,
  input  wire logic                 re,
  input  wire logic [ADDR_BITS-1:0] raddr,
  output logic      [7:0]           rdata
);

  localparam int unsigned DEPTH = 1 << ADDR_BITS;

  logic [7:0] mem_q [0:DEPTH-1];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_q[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: rtl/core/bpfc_addr_gen.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpfc_addr_gen
// framebuffer byte address, pixel bit select and screen bounds check
// ----------------------------------------------------------------------------
module bpfc_addr_gen (
  input  wire logic [6:0]       pixel_x,
  input  wire logic [6:0]       pixel_y,
  input  wire logic [6:0]       base_page,
  input  wire logic             fine_mode,
  input  wire logic             large_size,
  output logic      [15:0]      byte_addr,
  output bpfc_pkg::pix_sel_t    pix_sel
);

  logic [10:0] offset;
  logic [6:0]  page_sum;

  always_comb begin
    // quadrant bits sit above the 512-byte page offset
    if (fine_mode) begin
      offset = {large_size & pixel_y[6], large_size & pixel_x[6],
                pixel_y[5:1], pixel_x[5:2]};
      pix_sel.on_screen = large_size | (~pixel_x[6] & ~pixel_y[6]);
      pix_sel.bit_sel   = {pixel_x[1], pixel_y[0], pixel_x[0]};
    end else begin
      offset = {large_size & pixel_y[5], large_size & pixel_x[5],
                pixel_y[4:0], pixel_x[4:1]};
      pix_sel.on_screen = ~pixel_x[6] & ~pixel_y[6] &
                          (large_size | (~pixel_x[5] & ~pixel_y[5]));
      pix_sel.bit_sel   = {2'b00, pixel_x[0]};
    end
    pix_sel.fine = fine_mode;
    // base is page aligned, so only the page number takes a carry (wraps at 64k)
    page_sum  = base_page + {5'b00000, offset[10:9]};
    byte_addr = {page_sum, offset[8:0]};
  end

endmodule
`default_nettype wire

FILE: rtl/core/bpfc_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpfc_decode
// pixel code extraction and rgbi / grey colour decode
// ----------------------------------------------------------------------------
module bpfc_decode (
  input  wire logic               [7:0] mem_byte,
  input  wire bpfc_pkg::pix_sel_t       pix_sel,
  input  wire logic                     color_on,
  input  wire logic                     bright,
  input  wire logic               [2:0] plane_mask,
  output logic                    [7:0] red_level,
  output logic                    [7:0] green_level,
  output logic                    [7:0] blue_level
);

  logic [3:0] code;

  always_comb begin
    // code zero is black in both decodes: off screen and unlit pixels use it
    if (!pix_sel.on_screen) begin
      code = 4'h0;
    end else if (pix_sel.fine) begin
      code = mem_byte[pix_sel.bit_sel] ? {bright, plane_mask} : 4'h0;
    end else begin
      code = pix_sel.bit_sel[0] ? mem_byte[7:4] : mem_byte[3:0];
    end

    if (color_on) begin
      red_level   = bpfc_pkg::chan_level(code[0], code[3]);
      green_level = bpfc_pkg::chan_level(code[1], code[3]);
      blue_level  = bpfc_pkg::chan_level(code[2], code[3]);
    end else begin
      // grey is code * 17
      red_level   = {code, code};
      green_level = {code, code};
      blue_level  = {code, code};
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/bitmap_pixel_fetch_color_decode_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_pixel_fetch_color_decode_unit
// system memory with framebuffer pixel fetch and colour decode
// ----------------------------------------------------------------------------
// usage
// - command channel: a beat is taken on each clock edge with start high and
//   busy low; busy is always low, so one beat per clock is sustained
// - a write beat (op write) stores in_mem_data at in_mem_addr and gives no
//   result
// - a pixel beat (op pixel) reads one framebuffer byte and returns the
//   colour of (x,y) on out_* with out_strobe high for one cycle, after the
//   registered memory read and the result register
// - writes and reads of the memory each take one beat, so a write followed
//   at once by a read of the same byte returns the new value
// - results cannot be held off; the result register is overwritten every
//   cycle a new pixel result leaves the pipe
// - configuration: cfg_we with cfg_idx and cfg_wdata writes one register,
//   only while no pixel is in flight, a user rule that is not enforced
// - reset clears the config registers and the pipe valid bits; memory
//   content is undefined until written, with no clearing pass
// ----------------------------------------------------------------------------
module bitmap_pixel_fetch_color_decode_unit #(
  parameter int unsigned ADDR_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // command channel
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                in_op,
  input  wire logic [15:0]                         in_mem_addr,
  input  wire logic [7:0]                          in_mem_data,
  input  wire logic [6:0]                          in_pixel_x,
  input  wire logic [6:0]                          in_pixel_y,
  // result channel
  output logic                                     out_strobe,
  output logic      [7:0]                          out_red_level,
  output logic      [7:0]                          out_green_level,
  output logic      [7:0]                          out_blue_level,
  // configuration port
  input  wire logic                                cfg_we,
  input  wire logic [bpfc_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
  input  wire logic [bpfc_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

  // configuration registers
  logic [6:0] base_page_r;
  logic       fine_mode_r;
  logic       large_size_r;
  logic       color_on_r;
  logic       bright_r;
  logic [2:0] plane_mask_r;

  // pipe: fetch stage (memory read in flight) and result stage
  logic                 fetch_vld_r;
  bpfc_pkg::pix_sel_t   fetch_sel_r;
  logic                 out_vld_r;
  logic [7:0]           red_r;
  logic [7:0]           green_r;
  logic [7:0]           blue_r;

  logic                 beat_acc;
  logic                 mem_we;
  logic                 mem_re;
  logic [15:0]          pix_addr;
  bpfc_pkg::pix_sel_t   pix_sel;
  logic [7:0]           mem_rdata;
  logic [7:0]           red_nxt;
  logic [7:0]           green_nxt;
  logic [7:0]           blue_nxt;

  // every beat is a single memory access, so no back-pressure
  assign busy     = 1'b0;
  assign beat_acc = start & ~busy;
  assign mem_we   = beat_acc & (in_op == bpfc_pkg::OP_WRITE);
  assign mem_re   = beat_acc & (in_op == bpfc_pkg::OP_PIXEL);

  // configuration writes, unused indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_page_r  <= 7'd0;
      fine_mode_r  <= 1'b0;
      large_size_r <= 1'b0;
      color_on_r   <= 1'b0;
      bright_r     <= 1'b0;
      plane_mask_r <= 3'd0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        bpfc_pkg::REG_BASE_PAGE:  base_page_r  <= cfg_wdata[6:0];
        bpfc_pkg::REG_FINE_MODE:  fine_mode_r  <= cfg_wdata[0];
        bpfc_pkg::REG_LARGE_SIZE: large_size_r <= cfg_wdata[0];
        bpfc_pkg::REG_COLOR_ON:   color_on_r   <= cfg_wdata[0];
        bpfc_pkg::REG_BRIGHT:     bright_r     <= cfg_wdata[0];
        bpfc_pkg::REG_PLANE_MASK: plane_mask_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // pixel address and bit select from the current mode
  bpfc_addr_gen u_addr_gen (
    .pixel_x    (in_pixel_x),
    .pixel_y    (in_pixel_y),
    .base_page  (base_page_r),
    .fine_mode  (fine_mode_r),
    .large_size (large_size_r),
    .byte_addr  (pix_addr),
    .pix_sel    (pix_sel)
  );

  // system memory, addresses reduced to the implemented depth
  bpfc_mem #(
    .ADDR_BITS (ADDR_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (in_mem_addr[ADDR_BITS-1:0]),
    .wdata (in_mem_data),
    .re    (mem_re),
    .raddr (pix_addr[ADDR_BITS-1:0]),
    .rdata (mem_rdata)
  );

  // fetch stage: selection travels alongside the memory read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fetch_vld_r <= 1'b0;
    end else begin
      fetch_vld_r <= mem_re;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      fetch_sel_r <= pix_sel;
    end
  end

  // colour decode of the fetched byte
  bpfc_decode u_decode (
    .mem_byte    (mem_rdata),
    .pix_sel     (fetch_sel_r),
    .color_on    (color_on_r),
    .bright      (bright_r),
    .plane_mask  (plane_mask_r),
    .red_level   (red_nxt),
    .green_level (green_nxt),
    .blue_level  (blue_nxt)
  );

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= fetch_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fetch_vld_r) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_strobe      = out_vld_r;
  assign out_red_level   = red_r;
  assign out_green_level = green_r;
  assign out_blue_level  = blue_r;

  // a pixel beat yields a result through the fetch and result stages
  a_pixel_result: assert property (@(posedge clk) disable iff (!rst_n)
    mem_re |=> ##1 out_vld_r)
    else $error("pixel beat without result");

  // a write beat never starts a fetch
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (beat_acc && in_op == bpfc_pkg::OP_WRITE) |=> !fetch_vld_r)
    else $error("write beat started a fetch");

  // every result comes from a fetch
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> $past(fetch_vld_r))
    else $error("result without fetch");

  // off-screen pixels are black
  a_off_black: assert property (@(posedge clk) disable iff (!rst_n)
    (fetch_vld_r && !fetch_sel_r.on_screen) |=>
      (red_r == 8'd0 && green_r == 8'd0 && blue_r == 8'd0))
    else $error("off-screen pixel not black");

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the bitmap pixel fetch and colour decode unit. Byte writes and pixel
// requests go in through the command channel, and every register setting
// is visited: normal and fine pixels, small and large framebuffer, rgbi and
// grey decode, pages at both ends. A shadow copy of memory and registers
// predicts each colour beat, and that prediction is compared field by field
// with what comes back.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
} rgb_t;

class colour_scoreboard;
  bit [7:0]    vram [65536];
  bit          written [65536];
  bit [6:0]    base_page;
  bit          fine_mode, large_size, colour_on, bright;
  bit [2:0]    plane_mask;
  rgb_t        colour_q[$];
  int unsigned mismatches, pixel_beats, write_beats, colours_checked, settings;

  function int unsigned screen_side();
    if (fine_mode) return large_size ? 128 : 64;
    return large_size ? 64 : 32;
  endfunction

  function bit on_screen(bit [6:0] x, bit [6:0] y);
    return (x < screen_side()) && (y < screen_side());
  endfunction

  // byte holding pixel (x,y), page base added with 16-bit wrap
  function bit [15:0] fb_addr(bit [6:0] x, bit [6:0] y);
    int unsigned offset, quad, full;
    if (fine_mode && large_size) begin
      quad   = (y >> 6) * 2 + (x >> 6);
      offset = quad * 512 + ((y & 63) >> 1) * 16 + ((x & 63) >> 2);
    end else if (fine_mode) begin
      offset = (y >> 1) * 16 + (x >> 2);
    end else if (large_size) begin
      quad   = (y >> 5) * 2 + (x >> 5);
      offset = quad * 512 + (y & 31) * 16 + ((x & 31) >> 1);
    end else begin
      offset = y * 16 + (x >> 1);
    end
    full = {base_page, 9'b0} + offset;
    return full[15:0];
  endfunction

  function bit [7:0] rgbi_level(bit on, bit inten);
    if (on) return inten ? 8'd255 : 8'd170;
    return inten ? 8'd85 : 8'd0;
  endfunction

  function rgb_t code_to_rgb(bit [3:0] c);
    rgb_t p;
    if (colour_on) begin
      p.red   = rgbi_level(c[0], c[3]);
      p.green = rgbi_level(c[1], c[3]);
      p.blue  = rgbi_level(c[2], c[3]);
    end else begin
      p.red   = c * 8'd17;
      p.green = p.red;
      p.blue  = p.red;
    end
    return p;
  endfunction

  function rgb_t predict_colour(bit [6:0] x, bit [6:0] y);
    rgb_t     p;
    bit [7:0] b;
    bit [2:0] sel;
    p = '0;
    if (!on_screen(x, y)) return p;
    b = vram[fb_addr(x, y)];
    if (fine_mode) begin
      // 2x4 layout: bit0 x0, bit1 row parity, bit2 x1
      sel = {x[1], y[0], x[0]};
      if (b[sel]) p = code_to_rgb({bright, plane_mask});
    end else begin
      p = code_to_rgb(x[0] ? b[7:4] : b[3:0]);
    end
    return p;
  endfunction

  function void set_reg(bit [2:0] idx, bit [6:0] val);
    case (idx)
      bpfc_pkg::REG_BASE_PAGE:  base_page  = val;
      bpfc_pkg::REG_FINE_MODE:  fine_mode  = val[0];
      bpfc_pkg::REG_LARGE_SIZE: large_size = val[0];
      bpfc_pkg::REG_COLOR_ON:   colour_on  = val[0];
      bpfc_pkg::REG_BRIGHT:     bright     = val[0];
      bpfc_pkg::REG_PLANE_MASK: plane_mask = val[2:0];
      default: ;
    endcase
  endfunction

  function void note_beat(bit op, bit [15:0] addr, bit [7:0] data, bit [6:0] x, bit [6:0] y);
    if (op == bpfc_pkg::OP_WRITE) begin
      vram[addr]    = data;
      written[addr] = 1'b1;
      write_beats++;
    end else begin
      colour_q.push_back(predict_colour(x, y));
      pixel_beats++;
    end
  endfunction

  function void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  function void check_colour(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    rgb_t want;
    if (colour_q.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected colour beat, expected none, got %0d/%0d/%0d", $time, r, g, b);
      return;
    end
    want = colour_q.pop_front();
    colours_checked++;
    compare_field("red", want.red, r);
    compare_field("green", want.green, g);
    compare_field("blue", want.blue, b);
  endfunction

  function int unsigned pending();
    return colour_q.size();
  endfunction
endclass

module testbench;

  localparam int unsigned CYCLE_LIMIT            = 200000;
  localparam int unsigned PHASES                 = 10;
  localparam int unsigned RANDOM_BEATS_PER_PHASE = 133;
  // indexes past the last register, which the block must ignore
  localparam logic [2:0]  REG_SPARE_A            = 3'd6;
  localparam logic [2:0]  REG_SPARE_B            = 3'd7;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic       in_op;
  logic [15:0] in_mem_addr;
  logic [7:0] in_mem_data;
  logic [6:0] in_pixel_x;
  logic [6:0] in_pixel_y;
  logic       out_strobe;
  logic [7:0] out_red_level;
  logic [7:0] out_green_level;
  logic [7:0] out_blue_level;
  logic       cfg_we;
  logic [2:0] cfg_idx;
  logic [6:0] cfg_wdata;

  colour_scoreboard sb;
  bit               gaps_on;
  int unsigned      beats_sent = 0;
  int unsigned      cycle_count = 0;

  bitmap_pixel_fetch_color_decode_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_mem_addr     (in_mem_addr),
    .in_mem_data     (in_mem_data),
    .in_pixel_x      (in_pixel_x),
    .in_pixel_y      (in_pixel_y),
    .out_strobe      (out_strobe),
    .out_red_level   (out_red_level),
    .out_green_level (out_green_level),
    .out_blue_level  (out_blue_level),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog: a hung run fails rather than spinning forever
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // colour beats cannot be held off, so each strobe is checked at the edge
  // that ends its cycle; values read here are the ones before that edge
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      sb.check_colour(out_red_level, out_green_level, out_blue_level);
    end
  end

  // one command beat; random idle cycles in front of it while gaps are on.
  // the beat is noted right at the accepting edge so the expected colour
  // is worked out against the memory image as it stood then
  task automatic send_beat(input logic op, input logic [15:0] addr, input logic [7:0] data,
                           input logic [6:0] x, input logic [6:0] y);
    while (gaps_on && $urandom_range(99) < 29) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    in_op       <= op;
    in_mem_addr <= addr;
    in_mem_data <= data;
    in_pixel_x  <= x;
    in_pixel_y  <= y;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note_beat(op, addr, data, x, y);
    beats_sent++;
  endtask

  task automatic write_byte(input logic [15:0] addr, input logic [7:0] data);
    send_beat(bpfc_pkg::OP_WRITE, addr, data, 7'($urandom), 7'($urandom));
  endtask

  // a request for an on-screen pixel whose byte was never written gets that
  // byte filled first, so memory is never read before it holds a value
  task automatic ask_pixel(input logic [6:0] x, input logic [6:0] y);
    logic [15:0] a;
    if (sb.on_screen(x, y)) begin
      a = sb.fb_addr(x, y);
      if (!sb.written[a]) write_byte(a, 8'($urandom));
    end
    send_beat(bpfc_pkg::OP_PIXEL, 16'($urandom), 8'($urandom), x, y);
  endtask

  // sender holds off until every colour beat in flight is back
  task automatic hold_until_empty();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // quiet spell before register writes, covering the read pipe
  task automatic drain();
    hold_until_empty();
    repeat (4) @(posedge clk);
  endtask

  // cfg_we stays high across back-to-back writes; the caller lowers it
  task automatic cfg_put(input logic [2:0] idx, input logic [6:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  // phases 0..7 walk every fine/large/decode combination, later ones are
  // random; pages 0 and 127 and plane mask extremes are forced on the way.
  // unused upper data bits carry noise that the block has to drop
  task automatic program_regs(input int p);
    bit       fine, large_fb, colour, brt;
    bit [6:0] base;
    bit [2:0] mask;
    base     = 7'($urandom_range(0, 127));
    brt      = 1'($urandom);
    mask     = 3'($urandom);
    fine     = p[0];
    large_fb = p[1];
    colour   = !p[2];
    if (p >= 8) begin
      fine     = 1'($urandom);
      large_fb = 1'($urandom);
      colour   = 1'($urandom);
    end
    case (p)
      0: begin
        base = 7'd0;
        brt  = 1'b0;
        mask = 3'd0;
      end
      1, 7: begin
        brt  = 1'b1;
        mask = 3'd7;
      end
      3, 6: base = 7'd127;
      5: begin
        brt  = 1'b0;
        mask = 3'd0;
      end
      default: ;
    endcase
    cfg_put(bpfc_pkg::REG_BASE_PAGE, base);
    cfg_put(bpfc_pkg::REG_FINE_MODE, {6'($urandom), fine});
    cfg_put(bpfc_pkg::REG_LARGE_SIZE, {6'($urandom), large_fb});
    cfg_put(bpfc_pkg::REG_COLOR_ON, {6'($urandom), colour});
    cfg_put(bpfc_pkg::REG_BRIGHT, {6'($urandom), brt});
    cfg_put(bpfc_pkg::REG_PLANE_MASK, {4'($urandom), mask});
    cfg_put(p[0] ? REG_SPARE_A : REG_SPARE_B, 7'($urandom));
    cfg_we <= 1'b0;
    sb.settings++;
  endtask

  // normal small rgbi at page 0: bytes 0..7 hold all sixteen nibble codes,
  // low nibble even x, then two requests off the edge of the screen
  task automatic directed_colours();
    for (int k = 0; k < 8; k++) write_byte(16'(k), {4'(2 * k + 1), 4'(2 * k)});
    for (int x = 0; x < 16; x++) ask_pixel(7'(x), 7'd0);
    ask_pixel(7'd32, 7'd31);
    ask_pixel(7'd127, 7'd127);
  endtask

  task automatic random_phase(input int p);
    int unsigned target, side, sel, fb_bytes;
    bit          held;
    logic [6:0]  x, y;
    target = beats_sent + RANDOM_BEATS_PER_PHASE;
    held   = 1'b0;
    while (beats_sent < target) begin
      // once, midway through phase 2, let everything in flight come home
      if (p == 2 && !held && beats_sent + RANDOM_BEATS_PER_PHASE / 2 >= target) begin
        held = 1'b1;
        hold_until_empty();
      end
      side     = sb.screen_side();
      fb_bytes = sb.large_size ? 2048 : 512;
      sel      = $urandom_range(99);
      x        = 7'($urandom_range(0, side - 1));
      y        = 7'($urandom_range(0, side - 1));
      if (sel < 45) begin
        ask_pixel(x, y);
      end else if (sel < 55) begin
        // anywhere in the 7-bit range, pushed off screen where it can be
        x = 7'($urandom);
        y = 7'($urandom);
        if (side < 128 && sb.on_screen(x, y)) begin
          if ($urandom_range(1)) x = 7'($urandom_range(side, 127));
          else y = 7'($urandom_range(side, 127));
        end
        ask_pixel(x, y);
      end else if (sel < 65) begin
        // rewrite a pixel's byte and read it back at once
        write_byte(sb.fb_addr(x, y), 8'($urandom));
        ask_pixel(x, y);
      end else if (sel < 85) begin
        write_byte(16'({sb.base_page, 9'b0} + $urandom_range(0, fb_bytes - 1)), 8'($urandom));
      end else begin
        write_byte(16'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    sb          = new();
    gaps_on     = 1'b1;
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_op       <= bpfc_pkg::OP_WRITE;
    in_mem_addr <= 16'd0;
    in_mem_data <= 8'd0;
    in_pixel_x  <= 7'd0;
    in_pixel_y  <= 7'd0;
    cfg_we      <= 1'b0;
    cfg_idx     <= bpfc_pkg::REG_BASE_PAGE;
    cfg_wdata   <= 7'd0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < PHASES; p++) begin
      program_regs(p);
      // phase 8 runs flat out, with no idle cycles at all
      gaps_on = (p != 8);
      if (p == 0) directed_colours();
      random_phase(p);
      drain();
    end

    $display("%0d beats sent: %0d pixel requests, %0d byte writes",
             beats_sent, sb.pixel_beats, sb.write_beats);
    $display("%0d colours compared over %0d register settings, %0d mismatches",
             sb.colours_checked, sb.settings, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
